/* hw/rtl/adsr_pkg.sv */
// Shared types and constants for the ADSR envelope level block.
// No dependencies; used by every module under hw/rtl.
package adsr_pkg;

  // Level is unsigned fixed point with 16 fraction bits, 0..65536.
  localparam int LEVEL_W = 17;
  localparam logic [LEVEL_W-1:0] LEVEL_ONE = 17'h10000;

  // One quotient bit per divider cell.
  localparam int QUO_W = LEVEL_W;

  // Output beat: level padded up to whole bytes.
  localparam int OUT_DATA_W = 24;

  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ATTACK  = 2'd0,
    REG_DECAY   = 2'd1,
    REG_SUSTAIN = 2'd2,
    REG_RELEASE = 2'd3
  } reg_idx_t;

  // Travels with each item down the divider chain: the level the
  // segment starts from and whether the quotient is subtracted.
  typedef struct packed {
    logic [LEVEL_W-1:0] base;
    logic               sub;
  } tag_t;

endpackage

/* hw/rtl/adsr_front.sv */
// Front end: region decode and numerator multiply, two registered stages.
// Depends on adsr_pkg. Feeds the adsr_div_cell chain.
module adsr_front #(
  parameter int TIME_BITS = 24
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  up_valid,
  output logic                                  up_ready,
  input  logic [TIME_BITS-1:0]                  now_ticks,
  input  logic [TIME_BITS-1:0]                  note_off_ticks,
  input  logic [TIME_BITS-1:0]                  attack_ticks,
  input  logic [TIME_BITS-1:0]                  decay_ticks,
  input  logic [adsr_pkg::LEVEL_W-1:0]          sustain_level,
  input  logic [TIME_BITS-1:0]                  release_ticks,
  output logic                                  dn_valid,
  input  logic                                  dn_ready,
  output logic [TIME_BITS+adsr_pkg::LEVEL_W-1:0] dn_num,
  output logic [TIME_BITS-1:0]                  dn_dvs,
  output adsr_pkg::tag_t                        dn_tag
);

  localparam int NUM_W = TIME_BITS + adsr_pkg::LEVEL_W;

  logic [adsr_pkg::LEVEL_W-1:0] sus;
  logic [TIME_BITS:0]           t_ext;
  logic [TIME_BITS:0]           end_decay;
  logic [TIME_BITS:0]           end_release;

  logic [TIME_BITS-1:0]         x_next;
  logic [adsr_pkg::LEVEL_W-1:0] m_next;
  logic [TIME_BITS-1:0]         dvs_next;
  adsr_pkg::tag_t               tag_next;

  logic                         s1_valid;
  logic                         s1_ready;
  logic [TIME_BITS-1:0]         s1_x;
  logic [adsr_pkg::LEVEL_W-1:0] s1_m;
  logic [TIME_BITS-1:0]         s1_dvs;
  adsr_pkg::tag_t               s1_tag;
  logic                         s2_ready;

  assign sus = (sustain_level > adsr_pkg::LEVEL_ONE) ? adsr_pkg::LEVEL_ONE : sustain_level;
  assign t_ext       = {1'b0, now_ticks};
  assign end_decay   = {1'b0, attack_ticks} + {1'b0, decay_ticks};
  assign end_release = {1'b0, note_off_ticks} + {1'b0, release_ticks};

  // Divisor is nonzero in every dividing region: a zero-length segment
  // is always caught by the test before it. Flat regions divide 0 by 1.
  always_comb begin
    x_next        = '0;
    m_next        = '0;
    dvs_next      = TIME_BITS'(1);
    tag_next.base = '0;
    tag_next.sub  = 1'b0;
    if (now_ticks == '0) begin
      tag_next.base = '0;
    end else if (now_ticks <= attack_ticks) begin
      x_next   = now_ticks;
      m_next   = adsr_pkg::LEVEL_ONE;
      dvs_next = attack_ticks;
    end else if (t_ext <= end_decay) begin
      x_next        = now_ticks - attack_ticks;
      m_next        = adsr_pkg::LEVEL_ONE - sus;
      dvs_next      = decay_ticks;
      tag_next.base = adsr_pkg::LEVEL_ONE;
      tag_next.sub  = 1'b1;
    end else if (now_ticks <= note_off_ticks) begin
      tag_next.base = sus;
    end else if (t_ext <= end_release) begin
      x_next        = now_ticks - note_off_ticks;
      m_next        = sus;
      dvs_next      = release_ticks;
      tag_next.base = sus;
      tag_next.sub  = 1'b1;
    end
  end

  assign s2_ready = !dn_valid || dn_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign up_ready = s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && up_valid) begin
      s1_x   <= x_next;
      s1_m   <= m_next;
      s1_dvs <= dvs_next;
      s1_tag <= tag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (s2_ready) begin
      dn_valid <= s1_valid;
    end
  end

  // x <= divisor and m <= 65536, so the product fits NUM_W exactly
  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) begin
      dn_num <= NUM_W'(s1_x) * NUM_W'(s1_m);
      dn_dvs <= s1_dvs;
      dn_tag <= s1_tag;
    end
  end

endmodule

/* hw/rtl/adsr_div_cell.sv */
// One restoring-division cell: resolves one quotient bit per item.
// Depends on adsr_pkg. Instantiated in a chain by adsr_envelope_level.
module adsr_div_cell #(
  parameter int TIME_BITS = 24,
  parameter int SHIFT     = 0
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   up_valid,
  output logic                                   up_ready,
  input  logic [TIME_BITS+adsr_pkg::LEVEL_W-1:0] up_rem,
  input  logic [TIME_BITS-1:0]                   up_dvs,
  input  logic [adsr_pkg::QUO_W-1:0]             up_quo,
  input  adsr_pkg::tag_t                         up_tag,
  output logic                                   dn_valid,
  input  logic                                   dn_ready,
  output logic [TIME_BITS+adsr_pkg::LEVEL_W-1:0] dn_rem,
  output logic [TIME_BITS-1:0]                   dn_dvs,
  output logic [adsr_pkg::QUO_W-1:0]             dn_quo,
  output adsr_pkg::tag_t                         dn_tag
);

  localparam int NUM_W = TIME_BITS + adsr_pkg::LEVEL_W;

  logic [NUM_W-1:0] dvs_sh;
  logic             fits;

  assign dvs_sh   = NUM_W'(up_dvs) << SHIFT;
  assign fits     = (up_rem >= dvs_sh);
  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_rem <= fits ? (up_rem - dvs_sh) : up_rem;
      dn_dvs <= up_dvs;
      dn_quo <= {up_quo[adsr_pkg::QUO_W-2:0], fits};
      dn_tag <= up_tag;
    end
  end

endmodule

/* hw/rtl/adsr_envelope_level.sv */
// Top level of the linear ADSR envelope level block.
// Depends on adsr_pkg, adsr_front and adsr_div_cell.
//
// Usage:
//   s_axis carries one beat per sample: now_ticks and note_off_ticks.
//   m_axis returns one beat per input beat, in order: the level,
//   unsigned with 16 fraction bits (65536 = full level).
//   cfg_we/cfg_index/cfg_data write attack, decay, sustain and release;
//   write them only while no beat is in flight.
// Pipeline: region decode, multiply, one cell per quotient bit for 17 bits,
//   output register, each registered in that order.
// Throughput: one beat per cycle while m_axis is not stalled; every cell is a
//   pipeline stage that passes its item to the next cell each cycle it is not held.
// Reset: rst (synchronous) empties the pipeline and loads the register
//   defaults: zero-length attack, decay and release, full sustain.
// Stall: a held m_axis beat keeps its data; the stages behind it keep
//   filling, so s_axis_tready only drops once every stage holds a beat.
module adsr_envelope_level #(
  parameter int TIME_BITS = 24
) (
  input  logic                                clk,
  input  logic                                rst,
  // s_axis_tdata: now_ticks, note_off_ticks (from bit 0 up), zero pad
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [((2*TIME_BITS+7)/8)*8-1:0]    s_axis_tdata,
  // m_axis_tdata: level (from bit 0 up), zero pad
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [adsr_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  input  logic                                cfg_we,
  input  logic [adsr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [((TIME_BITS > adsr_pkg::LEVEL_W) ? TIME_BITS : adsr_pkg::LEVEL_W)-1:0]
                                              cfg_data
);

  localparam int NUM_W = TIME_BITS + adsr_pkg::LEVEL_W;
  localparam int QW    = adsr_pkg::QUO_W;

  // Configuration registers
  logic [TIME_BITS-1:0]         attack_ticks;
  logic [TIME_BITS-1:0]         decay_ticks;
  logic [adsr_pkg::LEVEL_W-1:0] sustain_level;
  logic [TIME_BITS-1:0]         release_ticks;

  always_ff @(posedge clk) begin
    if (rst) begin
      attack_ticks  <= '0;
      decay_ticks   <= '0;
      sustain_level <= adsr_pkg::LEVEL_ONE;
      release_ticks <= '0;
    end else if (cfg_we) begin
      case (adsr_pkg::reg_idx_t'(cfg_index))
        adsr_pkg::REG_ATTACK:  attack_ticks  <= cfg_data[TIME_BITS-1:0];
        adsr_pkg::REG_DECAY:   decay_ticks   <= cfg_data[TIME_BITS-1:0];
        adsr_pkg::REG_SUSTAIN: sustain_level <= cfg_data[adsr_pkg::LEVEL_W-1:0];
        adsr_pkg::REG_RELEASE: release_ticks <= cfg_data[TIME_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Links of the cell chain; link 0 is the front end's output
  logic                 c_valid [0:QW];
  logic                 c_ready [0:QW];
  logic [NUM_W-1:0]     c_rem   [0:QW];
  logic [TIME_BITS-1:0] c_dvs   [0:QW];
  logic [QW-1:0]        c_quo   [0:QW];
  adsr_pkg::tag_t       c_tag   [0:QW];

  adsr_front #(
    .TIME_BITS(TIME_BITS)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .up_valid       (s_axis_tvalid),
    .up_ready       (s_axis_tready),
    .now_ticks      (s_axis_tdata[TIME_BITS-1:0]),
    .note_off_ticks (s_axis_tdata[2*TIME_BITS-1:TIME_BITS]),
    .attack_ticks   (attack_ticks),
    .decay_ticks    (decay_ticks),
    .sustain_level  (sustain_level),
    .release_ticks  (release_ticks),
    .dn_valid       (c_valid[0]),
    .dn_ready       (c_ready[0]),
    .dn_num         (c_rem[0]),
    .dn_dvs         (c_dvs[0]),
    .dn_tag         (c_tag[0])
  );

  assign c_quo[0] = '0;

  // Cell i resolves quotient bit QW-1-i, most significant first.
  // The numerator is below divisor * 2^QW, so QW cells suffice.
  for (genvar i = 0; i < QW; i++) begin : g_cell
    adsr_div_cell #(
      .TIME_BITS(TIME_BITS),
      .SHIFT    (QW-1-i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .up_valid (c_valid[i]),
      .up_ready (c_ready[i]),
      .up_rem   (c_rem[i]),
      .up_dvs   (c_dvs[i]),
      .up_quo   (c_quo[i]),
      .up_tag   (c_tag[i]),
      .dn_valid (c_valid[i+1]),
      .dn_ready (c_ready[i+1]),
      .dn_rem   (c_rem[i+1]),
      .dn_dvs   (c_dvs[i+1]),
      .dn_quo   (c_quo[i+1]),
      .dn_tag   (c_tag[i+1])
    );
  end

  // Output register: apply the quotient to the segment's start level.
  // Attack adds (at most 65536); decay and release subtract at most base.
  logic [adsr_pkg::LEVEL_W-1:0] level;
  logic [adsr_pkg::LEVEL_W-1:0] level_next;

  assign level_next = c_tag[QW].sub ? (c_tag[QW].base - c_quo[QW])
                                    : (c_tag[QW].base + c_quo[QW]);
  assign c_ready[QW] = !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (c_ready[QW]) begin
      m_axis_tvalid <= c_valid[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (c_ready[QW] && c_valid[QW]) begin
      level <= level_next;
    end
  end

  assign m_axis_tdata = adsr_pkg::OUT_DATA_W'(level);

endmodule

/* hw/rtl/adsr_chk.sv */
// Port-level checker for adsr_envelope_level, bound to the top level.
// Depends on adsr_pkg.
module adsr_chk (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [adsr_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

  // Level never exceeds full scale and the pad bits stay clear
  a_level_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[adsr_pkg::LEVEL_W-1:0] <= adsr_pkg::LEVEL_ONE))
    else $error("level above full scale");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |->
      (m_axis_tdata[adsr_pkg::OUT_DATA_W-1:adsr_pkg::LEVEL_W] == '0))
    else $error("output pad bits set");

  // Input backpressure only while the output beat is stalled
  a_ready_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
    else $error("input stalled while output free");

  // A stalled beat holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled output beat changed");

  // Pipeline empty right after reset
  a_empty_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !m_axis_tvalid)
    else $error("output beat right after reset");

endmodule

bind adsr_envelope_level adsr_chk u_adsr_chk (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
